// ----- src/patch_list_write_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// Patch list write parser: assertion macros
// Shared concurrent assertion helpers. They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PATCH_LIST_WRITE_PARSER_CORE_DEFINES_SVH
`define PATCH_LIST_WRITE_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PLW_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define PLW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define PLW_ASSERT(lbl, ante, cons, msg)
`define PLW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/plw_pkg.sv -----
// ----------------------------------------------------------------------------
// Patch list write parser package
// Word types, result kinds and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package plw_pkg;

	localparam int unsigned LEN_W          = 16;
	localparam int unsigned POS_W          = 17;
	localparam int unsigned ADDR_W         = 35;
	localparam int unsigned DATA_W         = 32;
	localparam int unsigned MAX_WORDS_W    = 24;
	localparam int unsigned MAX_LIST_WORDS_DEF = 65535;

	localparam logic [DATA_W-1:0] END_MARK = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] HV_LIMIT = 32'h0004_0000;
	localparam logic [ADDR_W-1:0] ADDR_STEP = 35'd4;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_INVALID = 2'd2,
		KIND_BADLEN  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic              start_req;
	} patch_word_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic              hypervisor;
	} result_word_t;

endpackage

// ----- src/plw_in_stage.sv -----
// ----------------------------------------------------------------------------
// Patch list input stage
// Registers one incoming word; refills in the cycle the parser consumes it.
// ----------------------------------------------------------------------------
module plw_in_stage
	import plw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        patch_valid,
	output logic        patch_stall,
	input  patch_word_t patch,
	input  logic        fire,
	output logic        s1_valid,
	output patch_word_t s1_word
);

	logic        valid_s1;
	patch_word_t word_s1;
	logic        take;

	// load when empty or when the held word leaves this cycle
	assign take        = !valid_s1 || fire;
	assign patch_stall = !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= patch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && patch_valid) begin
			word_s1 <= patch;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_word  = word_s1;

endmodule

// ----- src/plw_parse.sv -----
// ----------------------------------------------------------------------------
// Patch list parse stage
// Record state machine, bounds checks, address remap and result decode.
// ----------------------------------------------------------------------------
`include "patch_list_write_parser_core_defines.svh"

module plw_parse
	import plw_pkg::*;
#(
	parameter int unsigned MAX_LIST_WORDS = MAX_LIST_WORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             list_length_we,
	input  logic [LEN_W-1:0] list_length_wdata,
	input  logic             s1_valid,
	input  patch_word_t      s1_word,
	output logic             fire,
	output logic             res_push,
	input  logic             res_ready,
	output result_word_t     res
);

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_SIZE = 2'd1,
		PH_DATA = 2'd2,
		PH_IDLE = 2'd3
	} phase_t;

	localparam logic [MAX_WORDS_W-1:0] MaxWords = MAX_WORDS_W'(MAX_LIST_WORDS);

	logic [LEN_W-1:0]  len_q;
	phase_t            phase_q;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] tgt_q;
	logic [DATA_W-1:0] left_q;
	logic              hv_q;

	phase_t            phase_n;
	logic [POS_W-1:0]  pos_n;
	logic [ADDR_W-1:0] tgt_n;
	logic [DATA_W-1:0] left_n;
	logic              hv_n;
	logic              emit;
	logic [LEN_W-1:0]  eff_len;

	// length in use is capped by the buffer size
	assign eff_len = ({{(MAX_WORDS_W-LEN_W){1'b0}}, len_q} > MaxWords) ?
		MaxWords[LEN_W-1:0] : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (list_length_we) begin
			len_q <= list_length_wdata;
		end
	end

	assign fire = s1_valid && res_ready;

	// next state and result for the word in s1
	always_comb begin
		phase_t            ph;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  pos1;
		logic [POS_W:0]    addr_end;
		logic [DATA_W:0]   size_end;
		logic [DATA_W-1:0] w;

		w        = s1_word.word;
		ph       = s1_word.start_req ? PH_ADDR : phase_q;
		pos      = s1_word.start_req ? '0 : pos_q;
		pos1     = pos + POS_W'(1);
		addr_end = {1'b0, pos} + (POS_W+1)'(2);
		size_end = {{(DATA_W+1-POS_W){1'b0}}, pos1} + {1'b0, w};

		phase_n = ph;
		pos_n   = pos;
		tgt_n   = s1_word.start_req ? '0 : tgt_q;
		left_n  = s1_word.start_req ? '0 : left_q;
		hv_n    = s1_word.start_req ? 1'b0 : hv_q;
		emit    = 1'b0;
		res     = '{kind: KIND_WRITE, write_address: '0, write_data: '0, hypervisor: 1'b0};

		case (ph)
			PH_ADDR: begin
				if (w == END_MARK) begin
					phase_n  = PH_IDLE;
					emit     = 1'b1;
					res.kind = KIND_DONE;
				end else if (addr_end > (POS_W+1)'(eff_len)) begin
					phase_n  = PH_IDLE;
					emit     = 1'b1;
					res.kind = KIND_INVALID;
				end else begin
					// hypervisor patch: page bits 17:16 move up to bits 34:33
					if (w < HV_LIMIT) begin
						hv_n  = 1'b1;
						tgt_n = {w[17:16], 15'd0, w[17:0]};
					end else begin
						hv_n  = 1'b0;
						tgt_n = {3'd0, w};
					end
					pos_n   = pos1;
					phase_n = PH_SIZE;
				end
			end
			PH_SIZE: begin
				pos_n = pos1;
				if (size_end >= (DATA_W+1)'(eff_len)) begin
					phase_n  = PH_IDLE;
					emit     = 1'b1;
					res.kind = KIND_BADLEN;
				end else begin
					left_n  = w;
					phase_n = (w == '0) ? PH_ADDR : PH_DATA;
				end
			end
			PH_DATA: begin
				emit              = 1'b1;
				res.kind          = KIND_WRITE;
				res.write_address = tgt_n;
				res.write_data    = w;
				res.hypervisor    = hv_n;
				tgt_n             = tgt_n + ADDR_STEP;
				pos_n             = pos1;
				left_n            = left_n - DATA_W'(1);
				if (left_n == '0) begin
					phase_n = PH_ADDR;
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	assign res_push = fire && emit;

	// parser state advances only when the word is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			pos_q   <= '0;
			tgt_q   <= '0;
			left_q  <= '0;
			hv_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			tgt_q   <= tgt_n;
			left_q  <= left_n;
			hv_q    <= hv_n;
		end
	end

	`PLW_ASSERT(a_data_left, phase_q == PH_DATA, left_q != '0, "data phase with no words left")
	`PLW_ASSERT_NEXT(a_err_idle, res_push && res.kind != KIND_WRITE, phase_q == PH_IDLE, "end or error did not idle")
	`PLW_ASSERT(a_idle_quiet, fire && phase_q == PH_IDLE && !s1_word.start_req, !res_push, "result while idle")

endmodule

// ----- src/plw_out_reg.sv -----
// ----------------------------------------------------------------------------
// Patch list result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module plw_out_reg
	import plw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         res_push,
	output logic         res_ready,
	input  result_word_t res,
	output logic         result_valid,
	input  logic         result_stall,
	output result_word_t result
);

	logic         valid_q;
	result_word_t result_q;
	logic         ready;

	// free when empty or when the held word is taken this cycle
	assign ready     = !valid_q || !result_stall;
	assign res_ready = ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res_push) begin
			result_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ----- src/patch_list_write_parser_core.sv -----
// A word accepted into the input stage register is parsed combinationally; its
// result word is held in the result register until downstream takes it.
// Throughput: one patch list word per cycle while result_stall is low; the
// parse stage state update is combinational, so words follow back to back.
// Reset (arst_n low) clears the list length, the parser state (expect address
// word, position zero) and both stage valid flags; payload registers keep data.
// ----------------------------------------------------------------------------
// Patch list write parser core
// Turns a stream of patch list words into byte-addressed write, end and error results.
// ----------------------------------------------------------------------------
module patch_list_write_parser_core
	import plw_pkg::*;
#(
	parameter int unsigned MAX_LIST_WORDS = MAX_LIST_WORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             list_length_we,
	input  logic [LEN_W-1:0] list_length_wdata,
	input  logic             patch_valid,
	output logic             patch_stall,
	input  patch_word_t      patch,
	output logic             result_valid,
	input  logic             result_stall,
	output result_word_t     result
);

	logic         s1_valid;
	patch_word_t  s1_word;
	logic         fire;
	logic         res_push;
	logic         res_ready;
	result_word_t res;

	plw_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.patch_valid (patch_valid),
		.patch_stall (patch_stall),
		.patch       (patch),
		.fire        (fire),
		.s1_valid    (s1_valid),
		.s1_word     (s1_word)
	);

	plw_parse #(
		.MAX_LIST_WORDS (MAX_LIST_WORDS)
	) u_parse (
		.clk               (clk),
		.arst_n            (arst_n),
		.list_length_we    (list_length_we),
		.list_length_wdata (list_length_wdata),
		.s1_valid          (s1_valid),
		.s1_word           (s1_word),
		.fire              (fire),
		.res_push          (res_push),
		.res_ready         (res_ready),
		.res               (res)
	);

	plw_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_push     (res_push),
		.res_ready    (res_ready),
		.res          (res),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
